[rtl/keb_pkg.sv]
// Package: key codes, byte constants and the encoder result type.
`default_nettype none
package keb_pkg;

	localparam logic [7:0] VK_BACKSPACE = 8'h08;
	localparam logic [7:0] VK_TABKEY    = 8'h09;
	localparam logic [7:0] VK_ENTER     = 8'h0D;
	localparam logic [7:0] VK_ESC       = 8'h1B;
	localparam logic [7:0] VK_PGUP      = 8'h21;
	localparam logic [7:0] VK_PGDN      = 8'h22;
	localparam logic [7:0] VK_ENDKEY    = 8'h23;
	localparam logic [7:0] VK_HOMEKEY   = 8'h24;
	localparam logic [7:0] VK_LEFTKEY   = 8'h25;
	localparam logic [7:0] VK_UPKEY     = 8'h26;
	localparam logic [7:0] VK_RIGHTKEY  = 8'h27;
	localparam logic [7:0] VK_DOWNKEY   = 8'h28;
	localparam logic [7:0] VK_INS       = 8'h2D;
	localparam logic [7:0] VK_DEL       = 8'h2E;

	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;

	typedef struct packed {
		logic        emit;
		logic [7:0]  seq_byte0;
		logic [7:0]  seq_byte1;
		logic [7:0]  seq_byte2;
		logic [7:0]  seq_byte3;
		logic [2:0]  seq_length;
		logic [15:0] repeat_count;
		logic        alt_prefix;
	} enc_result_t;

	typedef struct packed {
		logic        we;
		logic [15:0] value;
	} pend_update_t;

endpackage
`default_nettype wire

[rtl/key_event_to_terminal_bytes_top.sv]
// Top level: input register, encoder and result register for keyboard events.
// Each key event taken on the input channel is registered, encoded in the next
// stage and, if it yields bytes or an alt prefix, presented as one result from
// the result register; events that yield nothing are dropped silently. One
// event is taken every cycle while the result side keeps up; each event passes
// through the input register and then the result register. A high surrogate
// is held internally and joined with the next low surrogate.
`default_nettype none
module key_event_to_terminal_bytes_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        key_down,
	input  wire logic [7:0]  virtual_key,
	input  wire logic        shift_held,
	input  wire logic        alt_held,
	input  wire logic [15:0] char_code,
	input  wire logic [15:0] repeat_raw,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       seq_byte0,
	output logic [7:0]       seq_byte1,
	output logic [7:0]       seq_byte2,
	output logic [7:0]       seq_byte3,
	output logic [2:0]       seq_length,
	output logic [15:0]      repeat_count,
	output logic             alt_prefix
);

	logic        valid_s1;
	logic        key_down_s1, shift_held_s1, alt_held_s1;
	logic [7:0]  virtual_key_s1;
	logic [15:0] char_code_s1, repeat_raw_s1;
	logic        valid_s2;
	keb_pkg::enc_result_t  res_s2;
	keb_pkg::enc_result_t  enc_res;
	keb_pkg::pend_update_t pend_upd;
	logic [15:0] pending_q;
	logic        s2_free, advance;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	keb_encode u_encode (
		.key_down    (key_down_s1),
		.virtual_key (virtual_key_s1),
		.shift_held  (shift_held_s1),
		.alt_held    (alt_held_s1),
		.char_code   (char_code_s1),
		.repeat_raw  (repeat_raw_s1),
		.pending     (pending_q),
		.result      (enc_res),
		.pend_upd    (pend_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			pending_q <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= advance && enc_res.emit;
			if (advance && pend_upd.we)
				pending_q <= pend_upd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_down_s1    <= key_down;
			virtual_key_s1 <= virtual_key;
			shift_held_s1  <= shift_held;
			alt_held_s1    <= alt_held;
			char_code_s1   <= char_code;
			repeat_raw_s1  <= repeat_raw;
		end
		if (advance)
			res_s2 <= enc_res;
	end

	assign out_valid    = valid_s2;
	assign seq_byte0    = res_s2.seq_byte0;
	assign seq_byte1    = res_s2.seq_byte1;
	assign seq_byte2    = res_s2.seq_byte2;
	assign seq_byte3    = res_s2.seq_byte3;
	assign seq_length   = res_s2.seq_length;
	assign repeat_count = res_s2.repeat_count;
	assign alt_prefix   = res_s2.alt_prefix;

endmodule
`default_nettype wire

[rtl/keb_encode.sv]
// Encoder: named-key table, surrogate joining and UTF-8 encoding of one event.
`default_nettype none
module keb_encode (
	input  wire logic                 key_down,
	input  wire logic [7:0]           virtual_key,
	input  wire logic                 shift_held,
	input  wire logic                 alt_held,
	input  wire logic [15:0]          char_code,
	input  wire logic [15:0]          repeat_raw,
	input  wire logic [15:0]          pending,
	output keb_pkg::enc_result_t      result,
	output keb_pkg::pend_update_t     pend_upd
);

	logic [7:0]  nb0, nb1, nb2, nb3;
	logic [2:0]  nlen;
	logic        is_high, is_low;
	logic [10:0] hi_plus;
	logic [20:0] cp;

	always_comb begin
		nb0 = '0; nb1 = '0; nb2 = '0; nb3 = '0; nlen = '0;
		unique case (virtual_key)
			keb_pkg::VK_BACKSPACE: begin nb0 = keb_pkg::CH_DEL; nlen = 3'd1; end
			keb_pkg::VK_ENTER:     begin nb0 = keb_pkg::CH_CR;  nlen = 3'd1; end
			keb_pkg::VK_TABKEY: begin
				if (shift_held) begin
					nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "Z"; nlen = 3'd3;
				end else begin
					nb0 = keb_pkg::CH_TAB; nlen = 3'd1;
				end
			end
			keb_pkg::VK_ESC:      begin nb0 = keb_pkg::CH_ESC; nlen = 3'd1; end
			keb_pkg::VK_UPKEY:    begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "A"; nlen = 3'd3;
			end
			keb_pkg::VK_DOWNKEY:  begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "B"; nlen = 3'd3;
			end
			keb_pkg::VK_RIGHTKEY: begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "C"; nlen = 3'd3;
			end
			keb_pkg::VK_LEFTKEY:  begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "D"; nlen = 3'd3;
			end
			keb_pkg::VK_HOMEKEY:  begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "H"; nlen = 3'd3;
			end
			keb_pkg::VK_ENDKEY:   begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "F"; nlen = 3'd3;
			end
			keb_pkg::VK_INS: begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "2";
				nb3 = keb_pkg::CH_TILDE; nlen = 3'd4;
			end
			keb_pkg::VK_DEL: begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "3";
				nb3 = keb_pkg::CH_TILDE; nlen = 3'd4;
			end
			keb_pkg::VK_PGUP: begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "5";
				nb3 = keb_pkg::CH_TILDE; nlen = 3'd4;
			end
			keb_pkg::VK_PGDN: begin
				nb0 = keb_pkg::CH_ESC; nb1 = keb_pkg::CH_LBRK; nb2 = "6";
				nb3 = keb_pkg::CH_TILDE; nlen = 3'd4;
			end
			default: nlen = '0;
		endcase
	end

	assign is_high = (char_code >= keb_pkg::HI_SURR_FIRST) && (char_code <= keb_pkg::HI_SURR_LAST);
	assign is_low  = (char_code >= keb_pkg::LO_SURR_FIRST) && (char_code <= keb_pkg::LO_SURR_LAST);
	assign hi_plus = {1'b0, pending[9:0]} + 11'd64;
	assign cp      = {hi_plus, char_code[9:0]};

	always_comb begin
		result              = '0;
		result.repeat_count = (repeat_raw == 16'd0) ? 16'd1 : repeat_raw;
		pend_upd            = '0;
		if (!key_down) begin
			result.emit = 1'b0;
		end else if (nlen != 3'd0) begin
			result.emit       = 1'b1;
			result.seq_byte0  = nb0;
			result.seq_byte1  = nb1;
			result.seq_byte2  = nb2;
			result.seq_byte3  = nb3;
			result.seq_length = nlen;
		end else if (char_code != 16'd0) begin
			result.alt_prefix = alt_held;
			pend_upd.we       = 1'b1;
			if (is_high) begin
				pend_upd.value = char_code;
			end else if (is_low) begin
				if (pending != 16'd0) begin
					result.seq_byte0  = {5'b11110, cp[20:18]};
					result.seq_byte1  = {2'b10, cp[17:12]};
					result.seq_byte2  = {2'b10, cp[11:6]};
					result.seq_byte3  = {2'b10, cp[5:0]};
					result.seq_length = 3'd4;
				end
			end else if (char_code[15:7] == 9'd0) begin
				result.seq_byte0  = {1'b0, char_code[6:0]};
				result.seq_length = 3'd1;
			end else if (char_code[15:11] == 5'd0) begin
				result.seq_byte0  = {3'b110, char_code[10:6]};
				result.seq_byte1  = {2'b10, char_code[5:0]};
				result.seq_length = 3'd2;
			end else begin
				result.seq_byte0  = {4'b1110, char_code[15:12]};
				result.seq_byte1  = {2'b10, char_code[11:6]};
				result.seq_byte2  = {2'b10, char_code[5:0]};
				result.seq_length = 3'd3;
			end
			result.emit = (result.seq_length != 3'd0) || alt_held;
		end
	end

endmodule
`default_nettype wire

[rtl/keb_checker.sv]
// Checker: port-level assertions on the result channel, bound to the top level.
`default_nettype none
module keb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  seq_byte0,
	input wire logic [2:0]  seq_length,
	input wire logic [15:0] repeat_count,
	input wire logic        alt_prefix
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(seq_byte0) && $stable(seq_length)
			&& $stable(repeat_count) && $stable(alt_prefix))
		else $error("stalled result changed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seq_length <= 3'd4)
		else $error("sequence length out of range");

	a_empty_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seq_length == 3'd0 |-> alt_prefix)
		else $error("empty result without alt prefix");

	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_count != 16'd0)
		else $error("zero repeat count");

endmodule

bind key_event_to_terminal_bytes_top keb_checker u_keb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.seq_byte0    (seq_byte0),
	.seq_length   (seq_length),
	.repeat_count (repeat_count),
	.alt_prefix   (alt_prefix)
);
`default_nettype wire

[tb/sv/keb_sequence_checker.sv]
// Checker: predicts the terminal byte sequence of each key event and compares results.
module keb_sequence_checker
	import keb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        key_down,
	input  wire logic [7:0]  virtual_key,
	input  wire logic        shift_held,
	input  wire logic        alt_held,
	input  wire logic [15:0] char_code,
	input  wire logic [15:0] repeat_raw,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  seq_byte0,
	input  wire logic [7:0]  seq_byte1,
	input  wire logic [7:0]  seq_byte2,
	input  wire logic [7:0]  seq_byte3,
	input  wire logic [2:0]  seq_length,
	input  wire logic [15:0] repeat_count,
	input  wire logic        alt_prefix,
	output int               mismatch_count,
	output int               results_awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] held_high_surrogate = 16'h0000;
	enc_result_t expected_seqs [$];
	enc_result_t predicted;
	enc_result_t oldest;

	initial begin
		mismatch_count = 0;
		results_awaited = 0;
	end

	function automatic logic [34:0] utf8_of(input logic [20:0] cp);
		logic [7:0] b0, b1, b2, b3;
		logic [2:0] len;
		b0 = 8'h00;
		b1 = 8'h00;
		b2 = 8'h00;
		b3 = 8'h00;
		if (cp < 21'h80) begin
			b0 = cp[7:0];
			len = 3'd1;
		end else if (cp < 21'h800) begin
			b0 = {3'b110, cp[10:6]};
			b1 = {2'b10, cp[5:0]};
			len = 3'd2;
		end else if (cp < 21'h10000) begin
			b0 = {4'b1110, cp[15:12]};
			b1 = {2'b10, cp[11:6]};
			b2 = {2'b10, cp[5:0]};
			len = 3'd3;
		end else begin
			b0 = {5'b11110, cp[20:18]};
			b1 = {2'b10, cp[17:12]};
			b2 = {2'b10, cp[11:6]};
			b3 = {2'b10, cp[5:0]};
			len = 3'd4;
		end
		return {len, b0, b1, b2, b3};
	endfunction

	function automatic enc_result_t predict_sequence(input logic kd, input logic [7:0] vk,
			input logic sh, input logic alt, input logic [15:0] ch, input logic [15:0] rep);
		enc_result_t r;
		logic [34:0] enc;
		logic [20:0] hi_off;
		logic [20:0] lo_off;
		logic named;
		r = '0;
		enc = '0;
		named = 1'b1;
		if (!kd)
			return r;
		r.repeat_count = (rep == 16'd0) ? 16'd1 : rep;
		case (vk)
			VK_BACKSPACE: enc = {3'd1, CH_DEL, 24'h0};
			VK_ENTER:     enc = {3'd1, CH_CR, 24'h0};
			VK_TABKEY:    enc = sh ? {3'd3, CH_ESC, CH_LBRK, "Z", 8'h0}
				: {3'd1, CH_TAB, 24'h0};
			VK_ESC:       enc = {3'd1, CH_ESC, 24'h0};
			VK_UPKEY:     enc = {3'd3, CH_ESC, CH_LBRK, "A", 8'h0};
			VK_DOWNKEY:   enc = {3'd3, CH_ESC, CH_LBRK, "B", 8'h0};
			VK_RIGHTKEY:  enc = {3'd3, CH_ESC, CH_LBRK, "C", 8'h0};
			VK_LEFTKEY:   enc = {3'd3, CH_ESC, CH_LBRK, "D", 8'h0};
			VK_HOMEKEY:   enc = {3'd3, CH_ESC, CH_LBRK, "H", 8'h0};
			VK_ENDKEY:    enc = {3'd3, CH_ESC, CH_LBRK, "F", 8'h0};
			VK_INS:       enc = {3'd4, CH_ESC, CH_LBRK, "2", CH_TILDE};
			VK_DEL:       enc = {3'd4, CH_ESC, CH_LBRK, "3", CH_TILDE};
			VK_PGUP:      enc = {3'd4, CH_ESC, CH_LBRK, "5", CH_TILDE};
			VK_PGDN:      enc = {3'd4, CH_ESC, CH_LBRK, "6", CH_TILDE};
			default:      named = 1'b0;
		endcase
		if (!named) begin
			if (ch == 16'h0000)
				return r;
			r.alt_prefix = alt;
			if (ch >= HI_SURR_FIRST && ch <= HI_SURR_LAST) begin
				held_high_surrogate = ch;
			end else if (ch >= LO_SURR_FIRST && ch <= LO_SURR_LAST) begin
				if (held_high_surrogate != 16'h0000) begin
					hi_off = {5'b0, held_high_surrogate - HI_SURR_FIRST};
					lo_off = {5'b0, ch - LO_SURR_FIRST};
					enc = utf8_of(21'h10000 + (hi_off << 10) + lo_off);
				end
				held_high_surrogate = 16'h0000;
			end else begin
				enc = utf8_of({5'b0, ch});
				held_high_surrogate = 16'h0000;
			end
			if (enc[34:32] == 3'd0 && !alt)
				return r;
		end
		r.emit = 1'b1;
		{r.seq_length, r.seq_byte0, r.seq_byte1, r.seq_byte2, r.seq_byte3} = enc;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_seqs.size() == 0) begin
					report_mismatch("unexpected transaction", 32'd1, 32'd0);
				end else begin
					oldest = expected_seqs.pop_front();
					if (seq_byte0 !== oldest.seq_byte0)
						report_mismatch("seq_byte0", 32'(seq_byte0),
							32'(oldest.seq_byte0));
					if (seq_byte1 !== oldest.seq_byte1)
						report_mismatch("seq_byte1", 32'(seq_byte1),
							32'(oldest.seq_byte1));
					if (seq_byte2 !== oldest.seq_byte2)
						report_mismatch("seq_byte2", 32'(seq_byte2),
							32'(oldest.seq_byte2));
					if (seq_byte3 !== oldest.seq_byte3)
						report_mismatch("seq_byte3", 32'(seq_byte3),
							32'(oldest.seq_byte3));
					if (seq_length !== oldest.seq_length)
						report_mismatch("seq_length", 32'(seq_length),
							32'(oldest.seq_length));
					if (repeat_count !== oldest.repeat_count)
						report_mismatch("repeat_count", 32'(repeat_count),
							32'(oldest.repeat_count));
					if (alt_prefix !== oldest.alt_prefix)
						report_mismatch("alt_prefix", 32'(alt_prefix),
							32'(oldest.alt_prefix));
				end
			end
			if (in_valid && in_ready) begin
				predicted = predict_sequence(key_down, virtual_key, shift_held, alt_held,
					char_code, repeat_raw);
				if (predicted.emit)
					expected_seqs.push_back(predicted);
			end
			results_awaited = expected_seqs.size();
		end
	end

endmodule

[tb/sv/key_event_to_terminal_bytes_top_tb.sv]
// Testbench top: key event stimulus, handshake idling and the final verdict.
module key_event_to_terminal_bytes_top_tb;
	import keb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 100;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        key_down;
	logic [7:0]  virtual_key;
	logic        shift_held;
	logic        alt_held;
	logic [15:0] char_code;
	logic [15:0] repeat_raw;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  seq_byte0;
	logic [7:0]  seq_byte1;
	logic [7:0]  seq_byte2;
	logic [7:0]  seq_byte3;
	logic [2:0]  seq_length;
	logic [15:0] repeat_count;
	logic        alt_prefix;
	int          mismatch_count;
	int          results_awaited;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          cycle_count;

	logic [7:0] named_keys [14] = '{VK_BACKSPACE, VK_TABKEY, VK_ENTER, VK_ESC, VK_PGUP,
		VK_PGDN, VK_ENDKEY, VK_HOMEKEY, VK_LEFTKEY, VK_UPKEY, VK_RIGHTKEY, VK_DOWNKEY,
		VK_INS, VK_DEL};

	key_event_to_terminal_bytes_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_down     (key_down),
		.virtual_key  (virtual_key),
		.shift_held   (shift_held),
		.alt_held     (alt_held),
		.char_code    (char_code),
		.repeat_raw   (repeat_raw),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.seq_byte0    (seq_byte0),
		.seq_byte1    (seq_byte1),
		.seq_byte2    (seq_byte2),
		.seq_byte3    (seq_byte3),
		.seq_length   (seq_length),
		.repeat_count (repeat_count),
		.alt_prefix   (alt_prefix)
	);

	keb_sequence_checker seq_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_down        (key_down),
		.virtual_key     (virtual_key),
		.shift_held      (shift_held),
		.alt_held        (alt_held),
		.char_code       (char_code),
		.repeat_raw      (repeat_raw),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.seq_byte0       (seq_byte0),
		.seq_byte1       (seq_byte1),
		.seq_byte2       (seq_byte2),
		.seq_byte3       (seq_byte3),
		.seq_length      (seq_length),
		.repeat_count    (repeat_count),
		.alt_prefix      (alt_prefix),
		.mismatch_count  (mismatch_count),
		.results_awaited (results_awaited)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[key_event_to_terminal_bytes_top] ERROR");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Call at a falling edge; returns at the falling edge after the transaction.
	task automatic send_event(input logic kd, input logic [7:0] vk, input logic sh,
			input logic alt, input logic [15:0] ch, input logic [15:0] rep);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		key_down    <= kd;
		virtual_key <= vk;
		shift_held  <= sh;
		alt_held    <= alt;
		char_code   <= ch;
		repeat_raw  <= rep;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_event();
		logic [7:0]  vk;
		logic [15:0] ch;
		logic [15:0] rep;
		logic        alt;
		int          pick;
		pick = $urandom_range(99);
		vk = 8'($urandom);
		case (vk)
			VK_BACKSPACE, VK_TABKEY, VK_ENTER, VK_ESC, VK_PGUP, VK_PGDN, VK_ENDKEY,
			VK_HOMEKEY, VK_LEFTKEY, VK_UPKEY, VK_RIGHTKEY, VK_DOWNKEY, VK_INS,
			VK_DEL: vk = 8'h41;
			default: ;
		endcase
		rep = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
		alt = 1'($urandom);
		if (pick < 10) begin
			send_event(1'b0, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
				16'($urandom));
		end else if (pick < 25) begin
			send_event(1'b1, named_keys[$urandom_range(13)], 1'($urandom), 1'($urandom),
				16'($urandom), rep);
		end else if (pick < 50) begin
			send_event(1'b1, vk, 1'($urandom), alt,
				16'($urandom_range(HI_SURR_LAST, HI_SURR_FIRST)), rep);
			send_event(1'b1, vk, 1'($urandom), 1'($urandom),
				16'($urandom_range(LO_SURR_LAST, LO_SURR_FIRST)), 16'($urandom));
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: ch = 16'($urandom_range(16'h007F, 16'h0001));
				1: ch = 16'($urandom_range(16'h07FF, 16'h0080));
				2: ch = 16'($urandom_range(16'hD7FF, 16'h0800));
				default: ch = 16'($urandom_range(16'hFFFF, 16'hE000));
			endcase
			send_event(1'b1, vk, 1'($urandom), alt, ch, rep);
		end else begin
			send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
				16'($urandom));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		key_down    = 1'b0;
		virtual_key = 8'h00;
		shift_held  = 1'b0;
		alt_held    = 1'b0;
		char_code   = 16'h0000;
		repeat_raw  = 16'h0000;
		send_idle_pct = 22;
		recv_idle_pct = 60;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_event(1'b0, VK_ENTER, 1'b0, 1'b0, 16'h000D, 16'd3);
		for (int k = 0; k < 14; k++)
			send_event(1'b1, named_keys[k], 1'b0, k[0], (k[1] ? 16'hFFFF : 16'h0000),
				(k == 0) ? 16'd0 : ((k == 13) ? 16'hFFFF : 16'(k)));
		send_event(1'b1, VK_TABKEY, 1'b1, 1'b1, 16'h0009, 16'd2);
		send_event(1'b1, 8'hFF, 1'b1, 1'b1, 16'h0000, 16'd5);
		send_event(1'b1, 8'h41, 1'b0, 1'b1, 16'h0041, 16'd0);
		send_event(1'b1, 8'hFF, 1'b0, 1'b0, 16'h07FF, 16'hFFFF);
		send_event(1'b1, 8'h00, 1'b1, 1'b0, 16'hFFFF, 16'd1);
		send_event(1'b1, 8'h41, 1'b0, 1'b0, HI_SURR_FIRST, 16'd7);
		send_event(1'b1, 8'h41, 1'b0, 1'b0, LO_SURR_LAST, 16'd7);
		send_event(1'b1, 8'h41, 1'b0, 1'b1, HI_SURR_LAST, 16'd1);
		send_event(1'b1, 8'h41, 1'b0, 1'b0, 16'h0800, 16'd1);
		send_event(1'b1, 8'h41, 1'b0, 1'b1, LO_SURR_FIRST, 16'd9);
		send_event(1'b1, 8'h41, 1'b1, 1'b0, LO_SURR_FIRST, 16'd9);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_random_event();
			if (phase == 0) begin
				// hold off until the result side has drained
				in_valid <= 1'b0;
				@(negedge clk);
				while (results_awaited != 0)
					@(negedge clk);
			end
		end

		in_valid <= 1'b0;
		while (results_awaited != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[key_event_to_terminal_bytes_top] OK");
		else
			$display("[key_event_to_terminal_bytes_top] ERROR");
		$finish;
	end

endmodule
